FILE: src/assert_macros.svh
// Assertion macros shared by the checker file of the routing table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define RRT_ASSERT_MSG(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Clocked assertion with a generic failure message.
`define RRT_ASSERT(label, prop) `RRT_ASSERT_MSG(label, prop, "range table check failed")

`endif

FILE: src/rrt_pkg.sv
`default_nettype none

package rrt_pkg;

	localparam int MAX_RULES = 64;
	localparam int IDX_W = $clog2(MAX_RULES);
	localparam int CNT_W = $clog2(MAX_RULES + 1);
	localparam int TYPE_W = 16;
	localparam int TGT_W = 9;
	localparam int BE_W = 8;
	localparam int DEFAULT_RULES = 3;
	localparam int INIT_W = $clog2(DEFAULT_RULES);

	localparam logic [TGT_W-1:0] TGT_LOCAL = '1;

	typedef enum logic [2:0] {
		OUT_FORWARD = 3'd0,
		OUT_LOCAL = 3'd1,
		OUT_NOMATCH = 3'd2,
		OUT_ADD_OK = 3'd3,
		OUT_ADD_REJ = 3'd4
	} outcome_t;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_ADD = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ADD,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TYPE_W-1:0] first;
		logic [TYPE_W-1:0] last;
		logic [TGT_W-1:0] target;
	} entry_t;

	typedef struct packed {
		logic ins;
		entry_t data;
	} ins_cmd_t;

	function automatic entry_t default_entry(input logic [INIT_W-1:0] idx);
		entry_t e;
		case (idx)
			INIT_W'(0): begin
				e.first = 16'h0001;
				e.last = 16'h0FFF;
				e.target = TGT_LOCAL;
			end
			INIT_W'(1): begin
				e.first = 16'h1000;
				e.last = 16'h7FFF;
				e.target = '0;
			end
			default: begin
				e.first = 16'h8000;
				e.last = 16'hFFFF;
				e.target = '0;
			end
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

FILE: src/rrt_req_if.sv
`default_nettype none

interface rrt_req_if;
	logic valid;
	logic ready;
	logic op;
	logic [15:0] message_type;
	logic [15:0] range_start;
	logic [15:0] range_end;
	logic signed [8:0] target;

	modport source (
		output valid, op, message_type, range_start, range_end, target,
		input ready
	);

	modport sink (
		input valid, op, message_type, range_start, range_end, target,
		output ready
	);
endinterface

`default_nettype wire

FILE: src/rrt_rsp_if.sv
`default_nettype none

interface rrt_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] outcome;
	logic [7:0] backend;

	modport source (
		output valid, outcome, backend,
		input ready
	);

	modport sink (
		input valid, outcome, backend,
		output ready
	);
endinterface

`default_nettype wire

FILE: src/rrt_cell.sv
`default_nettype none

module rrt_cell import rrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ins_cmd_t cmd,
	input logic prev_lt,
	input logic prev_valid,
	input entry_t prev_data,
	output logic lt,
	output logic valid,
	output entry_t data
);

	logic valid_q;
	entry_t data_q;
	logic take;

	// A valid entry whose start is below the new start stays in place.
	assign lt = valid_q && (data_q.first < cmd.data.first);
	assign take = cmd.ins && !lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= prev_lt ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= prev_lt ? cmd.data : prev_data;
		end
	end

	assign valid = valid_q;
	assign data = data_q;

endmodule

`default_nettype wire

FILE: src/rrt_array.sv
`default_nettype none

module rrt_array import rrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ins_cmd_t cmd,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_idx,
	output entry_t rd_data
);

	logic cell_lt [MAX_RULES];
	logic cell_valid [MAX_RULES];
	entry_t cell_data [MAX_RULES];
	entry_t rd_sel;
	entry_t rd_s1;

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		if (i == 0) begin : g_head
			rrt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.prev_lt(1'b1),
				.prev_valid(1'b0),
				.prev_data('0),
				.lt(cell_lt[i]),
				.valid(cell_valid[i]),
				.data(cell_data[i])
			);
		end else begin : g_body
			rrt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.prev_lt(cell_lt[i-1]),
				.prev_valid(cell_valid[i-1]),
				.prev_data(cell_data[i-1]),
				.lt(cell_lt[i]),
				.valid(cell_valid[i]),
				.data(cell_data[i])
			);
		end
	end

	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < MAX_RULES; i++) begin
			if (rd_idx == IDX_W'(i)) begin
				rd_sel = cell_data[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= rd_sel;
		end
	end

	assign rd_data = rd_s1;

endmodule

`default_nettype wire

FILE: src/range_route_table_core.sv
// Message-type routing table with sorted inclusive ranges.
// The req channel carries one transaction per request: op selects a lookup of
// message_type or the addition of the rule range_start..range_end -> target.
// The rsp channel returns exactly one transaction per request, in order, with
// the outcome and, for a forwarded lookup, the backend number.
// Rules live in a row of cells, one rule per cell, kept sorted by start. An
// add is applied by all cells at the same clock edge: the cell at the
// insertion point takes the new rule and every cell after it takes the rule
// of its left neighbor. An add passes through ST_ADD and ST_DONE before its
// result is loaded into the output register. A lookup is a binary search in
// which every probe reads the cell at the midpoint through the registered
// read bus in ST_PROBE and compares in ST_CMP.
// One request is in flight at a time; the next one is accepted while the
// previous result still waits in the output register. When the receiver
// stalls, the finished result holds in the output register and the following
// request waits before loading its result.
// After reset the three default rules are loaded, one per cycle, and req is
// not ready while they load.
`default_nettype none

module range_route_table_core import rrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	rrt_req_if.sink req,
	rrt_rsp_if.source rsp
);

	state_t state_q;
	state_t state_d;
	logic [INIT_W-1:0] init_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hiex_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] mid;
	logic op_q;
	logic [TYPE_W-1:0] key_q;
	entry_t new_q;
	outcome_t res_outc_q;
	logic [BE_W-1:0] res_be_q;
	logic out_valid_q;
	outcome_t out_outc_q;
	logic [BE_W-1:0] out_be_q;

	ins_cmd_t cmd;
	entry_t rd_data;
	logic rd_en;
	logic accept;
	logic probe_live;
	logic key_below;
	logic key_above;
	logic add_rej;
	logic res_set;
	outcome_t res_outc;
	logic [BE_W-1:0] res_be;
	logic out_load;
	logic cnt_inc;
	logic go_left;
	logic go_right;

	assign accept = req.valid && req.ready;
	assign probe_live = lo_q < hiex_q;
	assign mid = lo_q + ((hiex_q - lo_q - CNT_W'(1)) >> 1);
	assign key_below = key_q < rd_data.first;
	assign key_above = key_q > rd_data.last;
	assign add_rej = (count_q == CNT_W'(MAX_RULES)) || (new_q.first > new_q.last);

	rrt_array u_array (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_en(rd_en),
		.rd_idx(mid[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_q == INIT_W'(DEFAULT_RULES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.op == OP_ADD) ? ST_ADD : ST_PROBE;
				end
			end
			ST_ADD: begin
				state_d = ST_DONE;
			end
			ST_PROBE: begin
				state_d = probe_live ? ST_CMP : ST_DONE;
			end
			ST_CMP: begin
				state_d = (key_below || key_above) ? ST_PROBE : ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		cmd = '0;
		rd_en = 1'b0;
		res_set = 1'b0;
		res_outc = OUT_NOMATCH;
		res_be = '0;
		out_load = 1'b0;
		cnt_inc = 1'b0;
		go_left = 1'b0;
		go_right = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.ins = 1'b1;
				cmd.data = default_entry(init_q);
				cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_ADD: begin
				res_set = 1'b1;
				if (add_rej) begin
					res_outc = OUT_ADD_REJ;
				end else begin
					res_outc = OUT_ADD_OK;
					cmd.ins = 1'b1;
					cmd.data = new_q;
					cnt_inc = 1'b1;
				end
			end
			ST_PROBE: begin
				rd_en = probe_live;
				if (!probe_live) begin
					res_set = 1'b1;
					res_outc = OUT_NOMATCH;
				end
			end
			ST_CMP: begin
				if (key_below) begin
					go_left = 1'b1;
				end else if (key_above) begin
					go_right = 1'b1;
				end else begin
					res_set = 1'b1;
					if (rd_data.target[TGT_W-1]) begin
						res_outc = OUT_LOCAL;
					end else begin
						res_outc = OUT_FORWARD;
						res_be = rd_data.target[BE_W-1:0];
					end
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				init_q <= init_q + INIT_W'(1);
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.op;
			key_q <= req.message_type;
			new_q.first <= req.range_start;
			new_q.last <= req.range_end;
			new_q.target <= req.target[TGT_W-1] ? TGT_LOCAL
				: {1'b0, $unsigned(req.target[BE_W-1:0])};
			lo_q <= '0;
			hiex_q <= count_q;
		end
		if (rd_en) begin
			mid_q <= mid;
		end
		if (go_left) begin
			hiex_q <= mid_q;
		end
		if (go_right) begin
			lo_q <= mid_q + CNT_W'(1);
		end
		if (res_set) begin
			res_outc_q <= res_outc;
			res_be_q <= res_be;
		end
		if (out_load) begin
			out_outc_q <= (op_q == OP_ADD) || (res_outc_q != OUT_FORWARD) ? res_outc_q
				: OUT_FORWARD;
			out_be_q <= (res_outc_q == OUT_FORWARD) ? res_be_q : '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.outcome = out_outc_q;
	assign rsp.backend = out_be_q;

endmodule

`default_nettype wire

FILE: src/rrt_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rrt_checker import rrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] outcome,
	input logic [7:0] backend
);

	`RRT_ASSERT(a_outcome_code, out_valid |-> (outcome == OUT_FORWARD || outcome == OUT_LOCAL || outcome == OUT_NOMATCH || outcome == OUT_ADD_OK || outcome == OUT_ADD_REJ))
	`RRT_ASSERT(a_backend_zero, out_valid && (outcome != OUT_FORWARD) |-> (backend == '0))
	`RRT_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)
	`RRT_ASSERT_MSG(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(backend), "stalled result changed")

endmodule

bind range_route_table_core rrt_checker u_rrt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.outcome(rsp.outcome),
	.backend(rsp.backend)
);

`default_nettype wire
